FILE: design/rrld_pkg.sv
// Package for the region run-length decoder.
// Holds the result word type, status codes and stream byte constants.
// No dependencies.
`timescale 1ns / 1ps

package rrld_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_SIGNATURE = 3'd2,
        ST_SIZE      = 3'd3,
        ST_ORIGIN    = 3'd4,
        ST_EMPTY     = 3'd5
    } rrld_status_t;

    localparam logic [7:0] SIG_ROWS = 8'h68;
    localparam logic [7:0] SIG_COLS = 8'h76;
    localparam logic [7:0] LINE_END = 8'hFF;

    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_FIN  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [8:0] left;
        logic [8:0] top;
        logic [8:0] right;
        logic [8:0] bottom;
        logic [2:0] status;
        logic       eor;
    } rrld_item_t;

    typedef struct packed {
        logic       rect_valid;
        logic       fin_valid;
        rrld_item_t rect;
        rrld_item_t fin;
    } rrld_push_t;

endpackage

FILE: design/region_run_length_decoder.sv
// Top level of the region run-length decoder: input word register, decoder, result queue.
// Depends on rrld_pkg, rrld_core and rrld_out_queue.
//
//   channel | direction | carries
//   s_*     | in        | one stream byte, tlast on the final byte
//   m_*     | out       | rectangle or end-of-stream status word, tlast on the status word
//
// One input word per cycle while the queue has room: each accepted word is decoded
// while it sits in the input register, and the result words it yields, up to two,
// enter a four-word queue. Result words leave at one per cycle while m_tready is high,
// and the input side stalls whenever the queue cannot take two more words.
// Reset is synchronous on aresetn and empties both the input register and the queue.
// A stall on m_tready backs up through the queue into s_tready.
`timescale 1ns / 1ps

module region_run_length_decoder #(
    parameter int MAX_EXTENT = 254
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [8:0] rect_left, [17:9] rect_top, [26:18] rect_right,
                                   // [35:27] rect_bottom, [38:36] status, [39] zero
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // end_of_region
);
    import rrld_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       room;
    logic       fire;
    rrld_push_t push;
    rrld_item_t head;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rrld_core #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .data_byte  (in_data_reg),
        .final_byte (in_last_reg),
        .push       (push)
    );

    rrld_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tready),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head)
    );

    assign m_tdata = {1'b0, head.status, head.bottom, head.right, head.top, head.left};
    assign m_tuser = head.kind;
    assign m_tlast = head.eor;

endmodule

FILE: design/rrld_core.sv
// Decoder state and per-byte decode for the region run-length decoder.
// Produces up to two result words per byte (a rectangle, then a status word).
// Depends on rrld_pkg.
`timescale 1ns / 1ps

module rrld_core #(
    parameter int MAX_EXTENT = 254
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output rrld_pkg::rrld_push_t push
);
    import rrld_pkg::*;

    localparam logic [7:0] MAX_EXT8 = 8'(MAX_EXTENT);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_START  = 5'b00010,
        PH_LENGTH = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [2:0]   hdr_idx_reg, hdr_idx_next;
    logic         vert_reg, vert_next;
    logic [7:0]   ox_reg, ox_next;
    logic [7:0]   oy_reg, oy_next;
    logic [7:0]   ew_reg, ew_next;
    logic [7:0]   eh_reg, eh_next;
    logic [8:0]   lpos_reg, lpos_next;
    logic [7:0]   pend_reg, pend_next;
    logic         any_reg, any_next;
    rrld_status_t err_reg, err_next;

    logic [7:0] lines;
    logic [7:0] span;
    logic [7:0] remain;
    logic [7:0] run_len;
    logic [8:0] run_base;
    logic [8:0] line_base;
    logic       start_in;

    assign lines     = vert_reg ? ew_reg : eh_reg;
    assign span      = vert_reg ? eh_reg : ew_reg;
    assign start_in  = pend_reg < span;
    assign remain    = span - pend_reg;
    assign run_len   = (data_byte > remain) ? remain : data_byte;
    assign run_base  = (vert_reg ? {1'b0, oy_reg} : {1'b0, ox_reg}) + {1'b0, pend_reg};
    assign line_base = (vert_reg ? {1'b0, ox_reg} : {1'b0, oy_reg}) + lpos_reg;

    always_comb begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        vert_next    = vert_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        ew_next      = ew_reg;
        eh_next      = eh_reg;
        lpos_next    = lpos_reg;
        pend_next    = pend_reg;
        any_next     = any_reg;
        err_next     = err_reg;

        push.rect_valid = 1'b0;
        push.fin_valid  = 1'b0;
        push.rect.kind  = KIND_RECT;
        push.rect.status = ST_OK;
        push.rect.eor   = 1'b0;
        if (vert_reg) begin
            push.rect.left   = line_base;
            push.rect.right  = line_base + 9'd1;
            push.rect.top    = run_base;
            push.rect.bottom = run_base + {1'b0, run_len};
        end else begin
            push.rect.left   = run_base;
            push.rect.right  = run_base + {1'b0, run_len};
            push.rect.top    = line_base;
            push.rect.bottom = line_base + 9'd1;
        end
        push.fin.kind   = KIND_FIN;
        push.fin.left   = '0;
        push.fin.top    = '0;
        push.fin.right  = '0;
        push.fin.bottom = '0;
        push.fin.status = ST_OK;
        push.fin.eor    = 1'b1;

        if (fire) begin
            case (phase_reg)
                PH_HEADER: begin
                    case (hdr_idx_reg)
                        3'd0: begin
                            if (data_byte == SIG_ROWS) begin
                                vert_next = 1'b0;
                            end else if (data_byte == SIG_COLS) begin
                                vert_next = 1'b1;
                            end else begin
                                vert_next = 1'b0;
                                err_next  = ST_SIGNATURE;
                            end
                        end
                        3'd1: ox_next = data_byte;
                        3'd2: oy_next = data_byte;
                        3'd3: ew_next = data_byte;
                        default: eh_next = data_byte;
                    endcase
                    if (hdr_idx_reg < 3'd4) begin
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                        if (final_byte) begin
                            err_next = ST_SHORT;
                        end
                    end else begin
                        if (err_reg == ST_OK) begin
                            if (ew_reg == 8'd0 || data_byte == 8'd0 ||
                                ew_reg > MAX_EXT8 || data_byte > MAX_EXT8) begin
                                err_next = ST_SIZE;
                            end else if (ox_reg >= MAX_EXT8 || oy_reg >= MAX_EXT8) begin
                                err_next = ST_ORIGIN;
                            end
                        end
                        phase_next = (err_next == ST_OK) ? PH_START : PH_ERROR;
                    end
                end
                PH_START: begin
                    if (!final_byte) begin
                        if (data_byte == LINE_END) begin
                            lpos_next = lpos_reg + 9'd1;
                            if (lpos_next >= {1'b0, lines}) begin
                                phase_next = PH_DONE;
                            end
                        end else begin
                            pend_next  = data_byte;
                            phase_next = PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH: begin
                    phase_next = PH_START;
                    if (start_in && run_len != 8'd0) begin
                        push.rect_valid = 1'b1;
                        any_next        = 1'b1;
                    end
                end
                default: ;
            endcase

            if (final_byte) begin
                push.fin_valid  = 1'b1;
                push.fin.status = (err_next == ST_OK && !any_next) ? ST_EMPTY : err_next;
                phase_next   = PH_HEADER;
                hdr_idx_next = '0;
                vert_next    = 1'b0;
                ox_next      = '0;
                oy_next      = '0;
                ew_next      = '0;
                eh_next      = '0;
                lpos_next    = '0;
                pend_next    = '0;
                any_next     = 1'b0;
                err_next     = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            vert_reg    <= 1'b0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            ew_reg      <= '0;
            eh_reg      <= '0;
            lpos_reg    <= '0;
            pend_reg    <= '0;
            any_reg     <= 1'b0;
            err_reg     <= ST_OK;
        end else begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            vert_reg    <= vert_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            ew_reg      <= ew_next;
            eh_reg      <= eh_next;
            lpos_reg    <= lpos_next;
            pend_reg    <= pend_next;
            any_reg     <= any_next;
            err_reg     <= err_next;
        end
    end

endmodule

FILE: design/rrld_out_queue.sv
// Four-word result queue for the region run-length decoder.
// Takes up to two words per cycle in order, hands out one per cycle while pop is high.
// Depends on rrld_pkg.
`timescale 1ns / 1ps

module rrld_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrld_pkg::rrld_push_t push,
    input  logic                 pop,
    output logic                 room,
    output logic                 head_valid,
    output rrld_pkg::rrld_item_t head
);
    import rrld_pkg::*;

    rrld_item_t slot_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] fin_addr;
    logic [2:0] n_push;
    logic       do_pop;

    assign do_pop     = pop && cnt_reg != 3'd0;
    assign n_push     = {2'b00, push.rect_valid} + {2'b00, push.fin_valid};
    assign fin_addr   = push.rect_valid ? wr_reg + 2'd1 : wr_reg;
    assign wr_next    = wr_reg + n_push[1:0];
    assign rd_next    = rd_reg + {1'b0, do_pop};
    assign cnt_next   = cnt_reg + n_push - {2'b00, do_pop};
    assign room       = (cnt_reg <= 3'd2) || (cnt_reg == 3'd3 && do_pop);
    assign head_valid = cnt_reg != 3'd0;
    assign head       = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (push.rect_valid && wr_reg == 2'(i)) begin
                slot_reg[i] <= push.rect;
            end else if (push.fin_valid && fin_addr == 2'(i)) begin
                slot_reg[i] <= push.fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sim/region_run_length_decoder_tb.sv
// Self-checking testbench for region_run_length_decoder: directed and random byte streams
// go in on s_*, every word on m_* is checked against a predicted rectangle or status word.
// Depends on rrld_pkg and the design sources; needs no files or arguments.
`timescale 1ns / 1ps

module region_run_length_decoder_tb;
    import rrld_pkg::*;

    localparam int MAX_EXT     = 254;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_WORDS = 1700;

    typedef enum logic [2:0] {
        P_HEADER,
        P_START,
        P_LENGTH,
        P_DONE,
        P_ERROR
    } parse_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    region_run_length_decoder #(
        .MAX_EXTENT(MAX_EXT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // decoder state mirrored by the prediction
    parse_phase_t parse_phase;
    int           hdr_idx;
    logic         vert_mode;
    logic [7:0]   org_x;
    logic [7:0]   org_y;
    logic [7:0]   ext_w;
    logic [7:0]   ext_h;
    logic [8:0]   line_pos;
    logic [7:0]   run_start;
    logic         rect_seen;
    rrld_status_t err_code;

    rrld_item_t awaited_words[$];
    rrld_item_t want;

    int mismatches = 0;
    int words_sent = 0;
    int streams_sent = 0;
    int rects_checked = 0;
    int status_checked = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int hold_req = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall pattern, long hold-off on request
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((cycle_count % 5) >= 2);
            endcase
        end
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 128);
        end else begin
            rx_mode_left--;
        end
    end

    function automatic void clear_decoder();
        parse_phase = P_HEADER;
        hdr_idx = 0;
        vert_mode = 1'b0;
        org_x = '0;
        org_y = '0;
        ext_w = '0;
        ext_h = '0;
        line_pos = '0;
        run_start = '0;
        rect_seen = 1'b0;
        err_code = ST_OK;
    endfunction

    task automatic decode_stream_byte(input logic [7:0] b, input logic fin);
        int lines;
        int span;
        int run_len;
        rrld_item_t w;
        lines = vert_mode ? ext_w : ext_h;
        span = vert_mode ? ext_h : ext_w;
        w = '0;
        case (parse_phase)
            P_HEADER: begin
                case (hdr_idx)
                    0: begin
                        if (b == SIG_ROWS) begin
                            vert_mode = 1'b0;
                        end else if (b == SIG_COLS) begin
                            vert_mode = 1'b1;
                        end else begin
                            vert_mode = 1'b0;
                            err_code = ST_SIGNATURE;
                        end
                    end
                    1: org_x = b;
                    2: org_y = b;
                    3: ext_w = b;
                    default: ext_h = b;
                endcase
                if (hdr_idx < 4) begin
                    hdr_idx++;
                    if (fin) err_code = ST_SHORT;
                end else begin
                    if (err_code == ST_OK) begin
                        if (ext_w == 0 || ext_h == 0 || ext_w > MAX_EXT || ext_h > MAX_EXT)
                            err_code = ST_SIZE;
                        else if (org_x >= MAX_EXT || org_y >= MAX_EXT)
                            err_code = ST_ORIGIN;
                    end
                    parse_phase = (err_code == ST_OK) ? P_START : P_ERROR;
                end
            end
            P_START: begin
                if (!fin) begin
                    if (b == LINE_END) begin
                        line_pos = line_pos + 9'd1;
                        if (line_pos >= lines) parse_phase = P_DONE;
                    end else begin
                        run_start = b;
                        parse_phase = P_LENGTH;
                    end
                end
            end
            P_LENGTH: begin
                parse_phase = P_START;
                if (run_start < span) begin
                    run_len = b;
                    if (run_len > span - run_start) run_len = span - run_start;
                    if (run_len > 0) begin
                        w.kind = KIND_RECT;
                        if (vert_mode) begin
                            w.left = 9'(int'(org_x) + line_pos);
                            w.right = 9'(org_x + line_pos + 1);
                            w.top = 9'(int'(org_y) + run_start);
                            w.bottom = 9'(org_y + run_start + run_len);
                        end else begin
                            w.left = 9'(int'(org_x) + run_start);
                            w.right = 9'(org_x + run_start + run_len);
                            w.top = 9'(int'(org_y) + line_pos);
                            w.bottom = 9'(org_y + line_pos + 1);
                        end
                        w.status = ST_OK;
                        w.eor = 1'b0;
                        awaited_words = {awaited_words, w};
                        rect_seen = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (fin) begin
            w = '0;
            w.kind = KIND_FIN;
            w.status = (err_code == ST_OK && !rect_seen) ? ST_EMPTY : err_code;
            w.eor = 1'b1;
            awaited_words = {awaited_words, w};
            clear_decoder();
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = awaited_words.pop_front();
                check_field("item_kind", want.kind, m_tuser);
                check_field("rect_left", want.left, m_tdata[8:0]);
                check_field("rect_top", want.top, m_tdata[17:9]);
                check_field("rect_right", want.right, m_tdata[26:18]);
                check_field("rect_bottom", want.bottom, m_tdata[35:27]);
                check_field("status", want.status, m_tdata[38:36]);
                check_field("pad", 0, m_tdata[39]);
                check_field("end_of_region", want.eor, m_tlast);
                if (m_tuser == KIND_FIN) status_checked++;
                else rects_checked++;
            end
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        decode_stream_byte(b, fin);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_stream(input logic [7:0] seq[$]);
        foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
        streams_sent++;
    endtask

    task automatic test_header_checks();
        logic [7:0] seq[$];
        seq = {8'h00};
        send_stream(seq);
        seq = {8'h41, 8'd0, 8'd0, 8'd1, 8'd1, 8'h12};
        send_stream(seq);
        seq = {SIG_ROWS, 8'd0, 8'd0, 8'd0, 8'd255};
        send_stream(seq);
        seq = {SIG_ROWS, 8'd254, 8'd0, 8'd1, 8'd1, 8'h5A};
        send_stream(seq);
        seq = {SIG_COLS, 8'd0, 8'd0, 8'd1, 8'd1};
        send_stream(seq);
    endtask

    task automatic test_row_clipping();
        logic [7:0] seq[$];
        // full-width run clipped, last column, start past extent, zero length, lone start
        seq = {SIG_ROWS, 8'd253, 8'd253, 8'd254, 8'd254,
               8'd0, 8'd255, 8'd253, 8'd1, 8'd254, 8'd5, 8'd3, 8'd0, LINE_END, 8'd7};
        send_stream(seq);
    endtask

    task automatic test_column_runs();
        logic [7:0] seq[$];
        // two columns, then bytes past the last line, final byte completing nothing
        seq = {SIG_COLS, 8'd0, 8'd0, 8'd2, 8'd254,
               8'd1, 8'd255, LINE_END, 8'd0, 8'd1, LINE_END, 8'h55, 8'hAA};
        send_stream(seq);
        // final byte in the length position completes the run
        seq = {SIG_COLS, 8'd5, 8'd6, 8'd3, 8'd3, 8'd1, 8'd9};
        send_stream(seq);
    endtask

    task automatic test_backpressure();
        logic [7:0] seq[$];
        gaps_on = 1'b0;
        seq = {SIG_ROWS, 8'd10, 8'd20, 8'd254, 8'd254};
        for (int i = 0; i < 40; i++) begin
            seq = {seq, 8'(i * 6)};
            seq = {seq, 8'd3};
        end
        seq = {seq, LINE_END};
        seq = {seq, 8'd0};
        hold_req = 400;
        send_stream(seq);
        gaps_on = 1'b1;
    endtask

    task automatic send_random_stream();
        logic [7:0] seq[$];
        int pick;
        int lines;
        int span;
        int n_lines;
        int n_runs;
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sig;
        pick = $urandom_range(0, 9);
        if (pick <= 7) begin
            sig = $urandom_range(0, 1) ? SIG_COLS : SIG_ROWS;
            if ($urandom_range(0, 7) == 0) begin
                w = 8'($urandom_range(1, MAX_EXT));
                h = 8'($urandom_range(1, MAX_EXT));
            end else begin
                w = 8'($urandom_range(1, 6));
                h = 8'($urandom_range(1, 6));
            end
            x = 8'($urandom_range(0, MAX_EXT - 1));
            y = 8'($urandom_range(0, MAX_EXT - 1));
            seq = {sig, x, y, w, h};
            lines = (sig == SIG_COLS) ? w : h;
            span = (sig == SIG_COLS) ? h : w;
            n_lines = (lines > 6) ? $urandom_range(1, 6) : lines;
            for (int li = 0; li < n_lines; li++) begin
                n_runs = $urandom_range(0, 3);
                for (int r = 0; r < n_runs; r++) begin
                    if ($urandom_range(0, 3) == 0) seq = {seq, 8'($urandom_range(0, 254))};
                    else seq = {seq, 8'($urandom_range(0, span - 1))};
                    if ($urandom_range(0, 3) == 0) seq = {seq, 8'($urandom_range(0, 255))};
                    else seq = {seq, 8'($urandom_range(0, span))};
                end
                seq = {seq, LINE_END};
            end
            repeat ($urandom_range(0, 3)) seq = {seq, 8'($urandom_range(0, 255))};
        end else if (pick == 8) begin
            case ($urandom_range(0, 2))
                0: sig = SIG_ROWS;
                1: sig = SIG_COLS;
                default: sig = 8'($urandom_range(0, 255));
            endcase
            seq = {sig};
            repeat (2) seq = {seq, 8'($urandom_range(0, 1) ? $urandom_range(240, 255)
                                                           : $urandom_range(0, 255))};
            repeat (2) begin
                case ($urandom_range(0, 3))
                    0: seq = {seq, 8'd0};
                    1: seq = {seq, 8'd255};
                    default: seq = {seq, 8'($urandom_range(0, 255))};
                endcase
            end
            repeat ($urandom_range(0, 6)) seq = {seq, 8'($urandom_range(0, 255))};
        end else begin
            repeat ($urandom_range(1, 10)) seq = {seq, 8'($urandom_range(0, 255))};
        end
        if ($urandom_range(0, 1)) seq = {seq, 8'($urandom_range(0, 255))};
        if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(1, seq.size());
            while (seq.size() > pick) void'(seq.pop_back());
        end
        send_stream(seq);
    endtask

    task automatic test_random_streams();
        int first;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) send_random_stream();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        clear_decoder();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_header_checks();
        test_row_clipping();
        test_column_runs();
        test_backpressure();
        test_random_streams();

        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d stream bytes in %0d streams, including a long output hold-off.",
                 words_sent, streams_sent);
        $display("Checked %0d rectangle words and %0d status words, %0d mismatches.",
                 rects_checked, status_checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
